### hw/rtl/psq_pkg.sv
// Pitch scale quantizer package: shared constants, payload and config structs,
// and the scale-mask helper functions used by the back end.
// No dependencies.
`timescale 1ns / 1ps

package psq_pkg;

   localparam int CHANNELS    = 16;
   localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [11:0] SCALE_MASK_RESET    = 12'd2741;
   localparam logic [1:0]  ROUND_SEL_RESET     = 2'd1;
   localparam logic        EQUAL_LIKELY_RESET  = 1'b0;
   localparam logic [15:0] PULSE_SAMPLES_RESET = 16'd48;

   typedef enum logic [1:0] {
      ROUND_DOWN    = 2'd0,
      ROUND_NEAREST = 2'd1,
      ROUND_UP      = 2'd2
   } round_type;

   typedef enum logic [1:0] {
      REG_SCALE_MASK    = 2'd0,
      REG_ROUND_SEL     = 2'd1,
      REG_EQUAL_LIKELY  = 2'd2,
      REG_PULSE_SAMPLES = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [11:0] scale_mask;
      logic [1:0]  round_sel;
      logic        equal_likely;
      logic [15:0] pulse_samples;
   } psq_cfg_type;

   // One classified sample on its way from the front end to the back end.
   typedef struct packed {
      logic [3:0]         channel;
      logic signed [7:0]  octave;
      logic [11:0]        frac;
      logic signed [16:0] root;
   } psq_item_type;

   // Highest enabled note at or below semitone n.
   function automatic logic [3:0] note_lower(input logic [11:0] en, input logic [3:0] n);
      logic [3:0] lo;
      lo = 4'd0;
      for (int i = 0; i < 12; i++) begin
         if (en[i] && (4'(i) <= n)) begin
            lo = 4'(i);
         end
      end
      return lo;
   endfunction

   // Lowest enabled note above semitone n, or 12 for the next octave's root.
   function automatic logic [3:0] note_upper(input logic [11:0] en, input logic [3:0] n);
      logic [3:0] hi;
      hi = 4'd12;
      for (int i = 11; i >= 1; i--) begin
         if (en[i] && (4'(i) > n)) begin
            hi = 4'(i);
         end
      end
      return hi;
   endfunction

   function automatic logic [3:0] note_count(input logic [11:0] en);
      logic [3:0] k;
      k = 4'd0;
      for (int i = 0; i < 12; i++) begin
         k = k + {3'd0, en[i]};
      end
      return k;
   endfunction

   // idx-th enabled note; any index past the last enabled note gives 12.
   function automatic logic [3:0] note_select(input logic [11:0] en, input logic [3:0] idx);
      logic [3:0] sel;
      logic [3:0] c;
      sel = 4'd12;
      c   = 4'd0;
      for (int i = 0; i < 12; i++) begin
         if (en[i]) begin
            if (c == idx) begin
               sel = 4'(i);
            end
            c = c + 4'd1;
         end
      end
      return sel;
   endfunction

endpackage

### hw/rtl/pitch_scale_quantizer_unit.sv
// Pitch scale quantizer top level: register file, front end, queue, back end.
// Depends on psq_pkg, psq_front, psq_queue and psq_back.
`timescale 1ns / 1ps

// Quantizes one channel's pitch sample (3072 LSB per volt, 256 LSB per
// semitone) to the nearest enabled note of a 12-note scale, relative to a
// per-sample root offset, and flags note changes per channel with a trigger
// pulse lasting pulse_samples samples. The block takes one sample per clock
// while req_stall is low and returns one result per sample, in order. The
// front end registers the sample, which then passes through the queue, the
// back end's three stages and the result register. A four-entry queue sits
// between front and back: with rsp_stall high the block keeps taking samples
// until the queue and the front register are full (up to nine samples in
// flight), then raises req_stall. Channel state (last pitch and remaining
// pulse length) lives in flip-flops cleared by reset, so there is no start-up
// sweep. Write the configuration registers only while no sample is in flight.

module pitch_scale_quantizer_unit (
   input  logic                clock,
   input  logic                reset,
   // sample input
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [3:0]          req_channel,
   input  logic signed [16:0]  req_cv_in,
   input  logic signed [16:0]  req_root_offset,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_channel_out,
   output logic signed [18:0]  rsp_cv_out,
   output logic                rsp_trigger,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   psq_pkg::psq_cfg_type  cfg_ff;
   psq_pkg::psq_cfg_type  cfg_in;
   psq_pkg::psq_item_type push_item;
   psq_pkg::psq_item_type head_item;
   logic                  csr_wr;
   logic                  q_full;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_valid;

   // register file; transfer completes on the access cycle
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            psq_pkg::REG_SCALE_MASK:    cfg_in.scale_mask    = csr_pwdata[11:0];
            psq_pkg::REG_ROUND_SEL:     cfg_in.round_sel     = csr_pwdata[1:0];
            psq_pkg::REG_EQUAL_LIKELY:  cfg_in.equal_likely  = csr_pwdata[0];
            psq_pkg::REG_PULSE_SAMPLES: cfg_in.pulse_samples = csr_pwdata[15:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_mask    <= psq_pkg::SCALE_MASK_RESET;
         cfg_ff.round_sel     <= psq_pkg::ROUND_SEL_RESET;
         cfg_ff.equal_likely  <= psq_pkg::EQUAL_LIKELY_RESET;
         cfg_ff.pulse_samples <= psq_pkg::PULSE_SAMPLES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, zero-extended
   always_comb begin
      case (csr_paddr[3:2])
         psq_pkg::REG_SCALE_MASK:    csr_prdata = {20'd0, cfg_ff.scale_mask};
         psq_pkg::REG_ROUND_SEL:     csr_prdata = {30'd0, cfg_ff.round_sel};
         psq_pkg::REG_EQUAL_LIKELY:  csr_prdata = {31'd0, cfg_ff.equal_likely};
         psq_pkg::REG_PULSE_SAMPLES: csr_prdata = {16'd0, cfg_ff.pulse_samples};
         default:                    csr_prdata = '0;
      endcase
   end

   // front end: offset removal and octave split
   psq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_cv_in       (req_cv_in),
      .req_root_offset (req_root_offset),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   // decouple the two halves so each can stall on its own
   psq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_item (head_item)
   );

   // back end: note choice, pitch rebuild, trigger, result register
   psq_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_item          (head_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_channel_out (rsp_channel_out),
      .rsp_cv_out      (rsp_cv_out),
      .rsp_trigger     (rsp_trigger)
   );

   // never push into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("front pushed into a full queue");

   // never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("back end popped an empty queue");

   // hold the back end while a result waits
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_stall) |-> !q_pop)
      else $error("queue popped while the result register was stalled");

   // stall the input only because the queue is full
   assert property (@(posedge clock) disable iff (reset) req_stall |-> q_full)
      else $error("input stalled with room in the queue");

endmodule

### hw/rtl/psq_front.sv
// Pitch scale quantizer front end: takes a sample, removes the root offset and
// splits the pitch into octave and octave fraction. Depends on psq_pkg.
`timescale 1ns / 1ps

module psq_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [3:0]           req_channel,
   input  logic signed [16:0]   req_cv_in,
   input  logic signed [16:0]   req_root_offset,
   input  logic                 q_full,
   output logic                 q_push,
   output psq_pkg::psq_item_type q_item
);

   logic               f_vld_ff;
   logic               f_vld_in;
   logic [3:0]         f_ch_ff;
   logic signed [17:0] f_raw_ff;
   logic signed [16:0] f_root_ff;
   logic               accept;

   logic [7:0]  q10;
   logic [8:0]  v;
   logic [16:0] div_prod;
   logic [7:0]  quot;
   logic [7:0]  octave;
   logic [9:0]  oct_x3;
   logic [19:0] rem;

   assign req_stall = f_vld_ff & q_full;
   assign accept    = req_valid & ~req_stall;
   assign q_push    = f_vld_ff & ~q_full;

   always_comb begin
      f_vld_in = f_vld_ff;
      if (accept) begin
         f_vld_in = 1'b1;
      end else if (q_push) begin
         f_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= f_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_ch_ff   <= req_channel;
         f_raw_ff  <= 18'(req_cv_in) - 18'(req_root_offset);
         f_root_ff <= req_root_offset;
      end
   end

   // floor(raw / 3072) = floor(floor(raw / 1024) / 3); bias by 129 to stay positive
   always_comb begin
      q10      = f_raw_ff[17:10];
      v        = {1'b0, ~q10[7], q10[6:0]} + 9'd1;
      div_prod = {8'd0, v} * 17'd171;
      quot     = div_prod[16:9];
      octave   = quot - 8'd43;
      oct_x3   = {{2{octave[7]}}, octave} + {octave[7], octave, 1'b0};
      rem      = {{2{f_raw_ff[17]}}, f_raw_ff} - {oct_x3, 10'd0};
   end

   always_comb begin
      q_item.channel = f_ch_ff;
      q_item.octave  = octave;
      q_item.frac    = rem[11:0];
      q_item.root    = f_root_ff;
   end

endmodule

### hw/rtl/psq_queue.sv
// Pitch scale quantizer decoupling queue between front and back end.
// Depends on psq_pkg.
`timescale 1ns / 1ps

module psq_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  psq_pkg::psq_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output psq_pkg::psq_item_type head_item
);

   psq_pkg::psq_item_type      entry_ff [psq_pkg::QUEUE_DEPTH];
   logic [psq_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [psq_pkg::QPTR_W-1:0] wr_ptr_in;
   logic [psq_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [psq_pkg::QPTR_W-1:0] rd_ptr_in;
   logic [psq_pkg::QPTR_W:0]   cnt_ff;
   logic [psq_pkg::QPTR_W:0]   cnt_in;

   assign full      = (cnt_ff == (psq_pkg::QPTR_W + 1)'(psq_pkg::QUEUE_DEPTH));
   assign valid     = (cnt_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (psq_pkg::QPTR_W + 1)'(push) - (psq_pkg::QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/psq_back.sv
// Pitch scale quantizer back end: note selection, pitch rebuild and the
// per-channel change trigger, ending in the result register. Depends on psq_pkg.
`timescale 1ns / 1ps

module psq_back (
   input  logic                  clock,
   input  logic                  reset,
   input  psq_pkg::psq_cfg_type  cfg,
   input  logic                  q_valid,
   input  psq_pkg::psq_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_channel_out,
   output logic signed [18:0]    rsp_cv_out,
   output logic                  rsp_trigger
);

   logic        adv;
   logic [11:0] en;

   // stage 1: note count times fraction
   logic                  b1_vld_ff, b1_vld_in;
   psq_pkg::psq_item_type b1_item_ff;
   logic [15:0]           b1_prod_ff;

   // stage 2: chosen note, octave wrap applied
   logic               b2_vld_ff, b2_vld_in;
   logic [3:0]         b2_ch_ff;
   logic [7:0]         b2_oct_ff;
   logic [3:0]         b2_note_ff;
   logic signed [16:0] b2_root_ff;

   // stage 3: rebuilt pitch
   logic        b3_vld_ff, b3_vld_in;
   logic [3:0]  b3_ch_ff;
   logic [18:0] b3_pitch_ff;
   logic        b3_in_range_ff;

   // result register
   logic        o_vld_ff, o_vld_in;
   logic [3:0]  o_ch_ff;
   logic [18:0] o_pitch_ff;
   logic        o_trig_ff;

   logic [18:0] last_ff  [psq_pkg::CHANNELS];
   logic [15:0] pulse_ff [psq_pkg::CHANNELS];

   logic [3:0]  n, lo, hi, note_norm, note_eq, note_sel, idx;
   logic [4:0]  lo_hi;
   logic [15:0] x;
   logic [12:0] idx_prod;
   logic [9:0]  oct_x3;
   logic [19:0] pitch_sum;

   logic [psq_pkg::CH_IDX_W-1:0] ch_idx;
   logic [15:0] pulse_old, pulse_arm, pulse_in;
   logic        changed, trig;
   logic        state_we;

   assign en    = cfg.scale_mask | 12'd1;
   assign adv   = ~o_vld_ff | ~rsp_stall;
   assign q_pop = adv & q_valid;

   assign b1_vld_in = adv ? q_valid   : b1_vld_ff;
   assign b2_vld_in = adv ? b1_vld_ff : b2_vld_ff;
   assign b3_vld_in = adv ? b2_vld_ff : b3_vld_ff;
   assign o_vld_in  = adv ? b3_vld_ff : o_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
         b2_vld_ff <= 1'b0;
         b3_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else begin
         b1_vld_ff <= b1_vld_in;
         b2_vld_ff <= b2_vld_in;
         b3_vld_ff <= b3_vld_in;
         o_vld_ff  <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_item_ff <= q_item;
         b1_prod_ff <= {12'd0, psq_pkg::note_count(en)} * {4'd0, q_item.frac};
      end
   end

   // stage 2 selection
   always_comb begin
      n     = b1_item_ff.frac[11:8];
      lo    = psq_pkg::note_lower(en, n);
      hi    = psq_pkg::note_upper(en, n);
      lo_hi = {1'b0, lo} + {1'b0, hi};
      case (cfg.round_sel)
         psq_pkg::ROUND_DOWN: begin
            note_norm = lo;
            x         = b1_prod_ff;
         end
         psq_pkg::ROUND_UP: begin
            note_norm = (b1_item_ff.frac == {lo, 8'd0}) ? lo : hi;
            x         = b1_prod_ff + 16'd3071;
         end
         default: begin
            note_norm = (b1_item_ff.frac >= {lo_hi, 7'd0}) ? hi : lo;
            x         = b1_prod_ff + 16'd1536;
         end
      endcase
      // x / 3072 as (x >> 10) / 3
      idx_prod = {7'd0, x[15:10]} * 13'd171;
      idx      = idx_prod[12:9];
      note_eq  = psq_pkg::note_select(en, idx);
      note_sel = cfg.equal_likely ? note_eq : note_norm;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b2_ch_ff   <= b1_item_ff.channel;
         b2_root_ff <= b1_item_ff.root;
         if (note_sel >= 4'd12) begin
            b2_note_ff <= 4'd0;
            b2_oct_ff  <= b1_item_ff.octave + 8'd1;
         end else begin
            b2_note_ff <= note_sel;
            b2_oct_ff  <= b1_item_ff.octave;
         end
      end
   end

   // stage 3: octave * 3072 + note * 256 + root
   always_comb begin
      oct_x3    = {{2{b2_oct_ff[7]}}, b2_oct_ff} + {b2_oct_ff[7], b2_oct_ff, 1'b0};
      pitch_sum = {oct_x3, 10'd0} + {8'd0, b2_note_ff, 8'd0}
                + {{3{b2_root_ff[16]}}, b2_root_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b3_ch_ff       <= b2_ch_ff;
         b3_pitch_ff    <= pitch_sum[18:0];
         b3_in_range_ff <= ({1'b0, b2_ch_ff} < psq_pkg::CH_LIMIT);
      end
   end

   // change detector and pulse counter, read and written in the same cycle
   always_comb begin
      ch_idx    = b3_ch_ff[psq_pkg::CH_IDX_W-1:0];
      pulse_old = pulse_ff[ch_idx];
      changed   = (b3_pitch_ff != last_ff[ch_idx]);
      pulse_arm = (changed && (cfg.pulse_samples > pulse_old)) ? cfg.pulse_samples
                                                               : pulse_old;
      trig      = (pulse_arm != 16'd0);
      pulse_in  = trig ? pulse_arm - 16'd1 : pulse_arm;
      state_we  = adv & b3_vld_ff & b3_in_range_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < psq_pkg::CHANNELS; i++) begin
            last_ff[i]  <= '0;
            pulse_ff[i] <= '0;
         end
      end else if (state_we) begin
         last_ff[ch_idx]  <= b3_pitch_ff;
         pulse_ff[ch_idx] <= pulse_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_ch_ff    <= b3_ch_ff;
         o_pitch_ff <= b3_pitch_ff;
         o_trig_ff  <= trig & b3_in_range_ff;
      end
   end

   assign rsp_valid       = o_vld_ff;
   assign rsp_channel_out = o_ch_ff;
   assign rsp_cv_out      = o_pitch_ff;
   assign rsp_trigger     = o_trig_ff;

endmodule

### sim/pitch_scale_quantizer_unit_tb.sv
// Self-checking testbench for pitch_scale_quantizer_unit: a directed table, then
// random samples over several scale settings, checked against an in-bench predictor.
// Depends on psq_pkg and the pitch_scale_quantizer_unit RTL.
`timescale 1ns / 1ps

module pitch_scale_quantizer_unit_tb;

   // Pitch grid: one octave and one semitone in LSB.
   localparam int OCTAVE_LSB   = 3072;
   localparam int SEMITONE_LSB = 256;

   // The rounding register also holds a fourth code, which the block reads as nearest.
   localparam logic [1:0] ROUND_MODE_SPARE = 2'd3;

   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 93;
   localparam int HOLD_CYCLES      = 60;   // long receiver hold-off, enough to fill the block
   localparam int SETTLE_CYCLES    = 4;    // idle margin before a register write
   localparam int TAIL_CYCLES      = 16;   // margin after the last result for any stray one
   localparam int MAX_REPORTS      = 40;
   // Longest legal stretch with no transfer is the receiver hold-off, or a drain
   // plus four register writes and reads.
   localparam int WATCHDOG_LIMIT   = 1000;

   typedef struct packed {
      logic [3:0]         channel;
      logic signed [18:0] cv_out;
      logic               trigger;
   } note_result_type;

   // One row of the directed table: either a register write or a sample, with the
   // expected result typed in where it is obvious.
   typedef struct packed {
      logic                   is_setting;
      psq_pkg::reg_index_type reg_idx;
      logic [15:0]            reg_value;
      logic [3:0]             channel;
      logic signed [16:0]     cv;
      logic signed [16:0]     root;
      logic                   typed;
      logic signed [18:0]     want_cv;
      logic                   want_trig;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [3:0]         req_channel;
   logic signed [16:0] req_cv_in;
   logic signed [16:0] req_root_offset;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [3:0]         rsp_channel_out;
   logic signed [18:0] rsp_cv_out;
   logic               rsp_trigger;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [3:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // Predictor copy of the configuration and channel history.
   logic [11:0] cfg_mask;
   logic [1:0]  cfg_round;
   logic        cfg_equal;
   logic [15:0] cfg_pulse;
   logic [18:0] last_pitch [16];
   logic [15:0] pulse_left [16];

   note_result_type expected_notes[$];
   note_result_type head;
   stim_row_type    directed_rows[$];

   int  errors;
   int  samples_sent;
   int  results_checked;
   int  triggers_seen;
   int  settings_used;
   bit  hold_request;
   int  stall_window;
   int  stall_style;
   int  idle_cycles;

   pitch_scale_quantizer_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_cv_in       (req_cv_in),
      .req_root_offset (req_root_offset),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_channel_out (rsp_channel_out),
      .rsp_cv_out      (rsp_cv_out),
      .rsp_trigger     (rsp_trigger),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Map the octave fraction (0..3071) to a note 0..12 under the current scale.
   function automatic int snap_note(input int frac);
      int notes [13];
      int count;
      int prod;
      int slot;
      int semi;
      int lo;
      int hi;
      count    = 1;
      notes[0] = 0;
      for (int i = 1; i < 12; i++) begin
         if (cfg_mask[i]) begin
            notes[count] = i;
            count++;
         end
      end
      notes[count] = 12;

      if (cfg_equal) begin
         // Each enabled note owns 1/count of the octave; work in exact integers.
         prod = count * frac;
         if (cfg_round == psq_pkg::ROUND_DOWN) slot = prod / OCTAVE_LSB;
         else if (cfg_round == psq_pkg::ROUND_UP) slot = (prod + OCTAVE_LSB - 1) / OCTAVE_LSB;
         else slot = (2 * prod + OCTAVE_LSB) / (2 * OCTAVE_LSB);
         if (slot > count) slot = count;
         return notes[slot];
      end

      // Bracket the semitone by the nearest enabled notes below and above.
      semi = frac / SEMITONE_LSB;
      lo   = 0;
      hi   = 12;
      for (int i = 0; i <= count; i++) begin
         if (notes[i] <= semi) lo = notes[i];
      end
      for (int i = count; i >= 0; i--) begin
         if (notes[i] > semi) hi = notes[i];
      end
      if (cfg_round == psq_pkg::ROUND_DOWN) return lo;
      if (cfg_round == psq_pkg::ROUND_UP) return (frac == lo * SEMITONE_LSB) ? lo : hi;
      return (frac >= (lo + hi) * (SEMITONE_LSB / 2)) ? hi : lo;
   endfunction

   // Quantize one sample and advance the channel's change detector.
   task automatic quantize_sample(input logic [3:0] ch, input logic signed [16:0] cv,
                                  input logic signed [16:0] root,
                                  output note_result_type r);
      int raw;
      int octave;
      int frac;
      int note;
      logic [18:0] pitch;
      raw = int'(cv) - int'(root);
      if (raw >= 0) octave = raw / OCTAVE_LSB;
      else octave = -((-raw + OCTAVE_LSB - 1) / OCTAVE_LSB);
      frac = raw - octave * OCTAVE_LSB;
      note = snap_note(frac);
      // note 12 is the root of the next octave
      if (note >= 12) begin
         octave++;
         note = 0;
      end
      pitch = 19'(octave * OCTAVE_LSB + note * SEMITONE_LSB + int'(root));

      if (pitch != last_pitch[ch]) begin
         last_pitch[ch] = pitch;
         if (cfg_pulse > pulse_left[ch]) pulse_left[ch] = cfg_pulse;
      end
      r.channel = ch;
      r.cv_out  = pitch;
      r.trigger = (pulse_left[ch] != 16'd0);
      if (r.trigger) pulse_left[ch] = pulse_left[ch] - 16'd1;
   endtask

   // ---------------------------------------------------------------------------
   // Directed table rows
   // ---------------------------------------------------------------------------

   function automatic stim_row_type item_row(input logic [3:0] ch, input int cv,
                                             input int root);
      stim_row_type row;
      row         = '0;
      row.channel = ch;
      row.cv      = 17'(cv);
      row.root    = 17'(root);
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic [3:0] ch, input int cv,
                                                input int root, input int want_cv,
                                                input logic want_trig);
      stim_row_type row;
      row           = item_row(ch, cv, root);
      row.typed     = 1'b1;
      row.want_cv   = 19'(want_cv);
      row.want_trig = want_trig;
      return row;
   endfunction

   function automatic stim_row_type setting_row(input psq_pkg::reg_index_type idx,
                                                input logic [15:0] value);
      stim_row_type row;
      row            = '0;
      row.is_setting = 1'b1;
      row.reg_idx    = idx;
      row.reg_value  = value;
      return row;
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers (the driving tasks start and end right after a falling edge)
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int want, input int got);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // Offer one sample, hold it until the transfer, then record what it must produce.
   task automatic send_sample(input logic [3:0] ch, input logic signed [16:0] cv,
                              input logic signed [16:0] root, input logic typed,
                              input logic signed [18:0] want_cv, input logic want_trig);
      note_result_type predicted;
      req_valid       <= 1'b1;
      req_channel     <= ch;
      req_cv_in       <= cv;
      req_root_offset <= root;
      do @(posedge clock); while (req_stall);
      quantize_sample(ch, cv, root, predicted);
      // typed rows still run the predictor so the channel history stays in step
      if (typed) begin
         predicted.cv_out  = want_cv;
         predicted.trigger = want_trig;
      end
      expected_notes.push_back(predicted);
      samples_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every sample in flight has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_notes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic check_register(input psq_pkg::reg_index_type idx, input logic [31:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         report_mismatch($sformatf("readback of %s", idx.name()), int'(want), int'(csr_prdata));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_register(input psq_pkg::reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         psq_pkg::REG_SCALE_MASK:    cfg_mask  = value[11:0];
         psq_pkg::REG_ROUND_SEL:     cfg_round = value[1:0];
         psq_pkg::REG_EQUAL_LIKELY:  cfg_equal = value[0];
         psq_pkg::REG_PULSE_SAMPLES: cfg_pulse = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      check_register(idx, value);
   endtask

   task automatic apply_setting(input logic [11:0] mask, input logic [1:0] mode,
                                input logic equal, input logic [15:0] pulse);
      settle();
      write_register(psq_pkg::REG_SCALE_MASK, {20'd0, mask});
      write_register(psq_pkg::REG_ROUND_SEL, {30'd0, mode});
      write_register(psq_pkg::REG_EQUAL_LIKELY, {31'd0, equal});
      write_register(psq_pkg::REG_PULSE_SAMPLES, {16'd0, pulse});
      settings_used++;
   endtask

   // ---------------------------------------------------------------------------
   // Result side: stall pattern and checker
   // ---------------------------------------------------------------------------

   // Stall in windows of a random style; on request, hold off for a long stretch.
   initial begin
      rsp_stall    = 1'b0;
      stall_window = 0;
      stall_style  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            if (stall_window == 0) begin
               stall_style  = $urandom_range(0, 3);
               stall_window = $urandom_range(16, 96);
            end
            stall_window--;
            case (stall_style)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Compare each result transfer with the oldest pending prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_notes.size() == 0) begin
            report_mismatch("result with no sample pending, cv_out", 0, int'(rsp_cv_out));
         end else begin
            head = expected_notes.pop_front();
            results_checked++;
            if (rsp_trigger === 1'b1) triggers_seen++;
            if (rsp_channel_out !== head.channel) begin
               report_mismatch("channel_out", int'(head.channel), int'(rsp_channel_out));
            end
            if (rsp_cv_out !== head.cv_out) begin
               report_mismatch($sformatf("cv_out on channel %0d", head.channel),
                               int'(head.cv_out), int'(rsp_cv_out));
            end
            if (rsp_trigger !== head.trigger) begin
               report_mismatch($sformatf("trigger on channel %0d", head.channel),
                               int'(head.trigger), int'(rsp_trigger));
            end
         end
      end
   end

   // Abort when nothing moves on any port for too long.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, expected_notes.size());
      $display("[pitch_scale_quantizer_unit] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   initial begin
      int          burst_left;
      int          rush_left;
      bit          gaps_on;
      logic [3:0]  ch;
      int          cv;
      int          root;
      int          last_cv [16];
      int          last_root [16];
      logic [11:0] mask;
      logic [1:0]  mode;
      logic        equal;
      logic [15:0] pulse;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_channel     = '0;
      req_cv_in       = '0;
      req_root_offset = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      hold_request    = 1'b0;
      errors          = 0;
      samples_sent    = 0;
      results_checked = 0;
      triggers_seen   = 0;
      settings_used   = 1;
      cfg_mask        = psq_pkg::SCALE_MASK_RESET;
      cfg_round       = psq_pkg::ROUND_SEL_RESET;
      cfg_equal       = psq_pkg::EQUAL_LIKELY_RESET;
      cfg_pulse       = psq_pkg::PULSE_SAMPLES_RESET;
      for (int i = 0; i < 16; i++) begin
         last_pitch[i] = '0;
         pulse_left[i] = '0;
         last_cv[i]    = 0;
         last_root[i]  = 0;
      end

      // Reset scale is the major scale {0,2,4,5,7,9,11}, round nearest, 48-sample pulse.
      directed_rows.push_back(checked_row(0, 0, 0, 0, 1'b0));          // same as cleared history
      directed_rows.push_back(checked_row(0, 256, 0, 512, 1'b1));      // halfway to note 2 goes up
      directed_rows.push_back(checked_row(1, 65535, -65536, 65280, 1'b1));  // top of range
      directed_rows.push_back(checked_row(2, -65536, 65535, -65537, 1'b1)); // bottom of range
      directed_rows.push_back(checked_row(15, 3071, 0, 3072, 1'b1));   // wraps to next octave
      directed_rows.push_back(checked_row(3, -1, 0, 0, 1'b0));         // wraps back to zero
      directed_rows.push_back(setting_row(psq_pkg::REG_ROUND_SEL, 16'(psq_pkg::ROUND_DOWN)));
      directed_rows.push_back(item_row(4, 767, 0));
      directed_rows.push_back(item_row(4, 3071, 100));
      directed_rows.push_back(setting_row(psq_pkg::REG_ROUND_SEL, 16'(psq_pkg::ROUND_UP)));
      directed_rows.push_back(item_row(5, 512, 0));                    // exactly on a note
      directed_rows.push_back(item_row(5, 513, 0));
      directed_rows.push_back(setting_row(psq_pkg::REG_ROUND_SEL, 16'(ROUND_MODE_SPARE)));
      directed_rows.push_back(item_row(6, 1151, 0));
      directed_rows.push_back(item_row(6, 1152, 0));
      directed_rows.push_back(setting_row(psq_pkg::REG_EQUAL_LIKELY, 16'd1));
      directed_rows.push_back(item_row(7, 1535, 0));
      directed_rows.push_back(item_row(7, 1536, 0));
      directed_rows.push_back(setting_row(psq_pkg::REG_ROUND_SEL, 16'(psq_pkg::ROUND_DOWN)));
      directed_rows.push_back(item_row(7, 3071, 0));
      directed_rows.push_back(setting_row(psq_pkg::REG_ROUND_SEL, 16'(psq_pkg::ROUND_UP)));
      directed_rows.push_back(item_row(8, 1, 0));
      directed_rows.push_back(item_row(8, 0, 0));
      directed_rows.push_back(setting_row(psq_pkg::REG_SCALE_MASK, 16'd0));   // root only
      directed_rows.push_back(item_row(9, 1535, 0));
      directed_rows.push_back(item_row(9, 1536, 0));
      directed_rows.push_back(setting_row(psq_pkg::REG_EQUAL_LIKELY, 16'd0));
      directed_rows.push_back(setting_row(psq_pkg::REG_SCALE_MASK, 16'hFFF)); // chromatic
      directed_rows.push_back(item_row(10, 127, 0));
      directed_rows.push_back(item_row(10, 128, 0));
      // zero pulse length: channel 0 keeps its running pulse, channel 11 gets none
      directed_rows.push_back(setting_row(psq_pkg::REG_PULSE_SAMPLES, 16'd0));
      directed_rows.push_back(item_row(0, 1000, 0));
      directed_rows.push_back(item_row(11, 1000, 0));
      directed_rows.push_back(setting_row(psq_pkg::REG_PULSE_SAMPLES, 16'd1));
      directed_rows.push_back(item_row(11, 2000, 0));
      directed_rows.push_back(item_row(11, 2000, 0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Registers must come out of reset at their documented values.
      check_register(psq_pkg::REG_SCALE_MASK, 32'(psq_pkg::SCALE_MASK_RESET));
      check_register(psq_pkg::REG_ROUND_SEL, 32'(psq_pkg::ROUND_SEL_RESET));
      check_register(psq_pkg::REG_EQUAL_LIKELY, 32'(psq_pkg::EQUAL_LIKELY_RESET));
      check_register(psq_pkg::REG_PULSE_SAMPLES, 32'(psq_pkg::PULSE_SAMPLES_RESET));

      // Walk the directed table: samples back to back, a settle before each write.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_setting) begin
            settle();
            write_register(directed_rows[i].reg_idx, 32'(directed_rows[i].reg_value));
            settings_used++;
         end else begin
            send_sample(directed_rows[i].channel, directed_rows[i].cv, directed_rows[i].root,
                        directed_rows[i].typed, directed_rows[i].want_cv,
                        directed_rows[i].want_trig);
         end
      end

      // Random phases: a fresh scale setting each, extremes first and last.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: apply_setting(12'hFFF, psq_pkg::ROUND_DOWN, 1'b0, 16'hFFFF);
            1: apply_setting(12'h000, psq_pkg::ROUND_UP, 1'b1, 16'd1);
            2: apply_setting(psq_pkg::SCALE_MASK_RESET, psq_pkg::ROUND_NEAREST, 1'b1, 16'd0);
            3: apply_setting(12'($urandom()), ROUND_MODE_SPARE, 1'b0, 16'd2);
            RANDOM_PHASES - 1: apply_setting(12'hFFE, psq_pkg::ROUND_UP, 1'b0, 16'd3);
            default: begin
               mask  = 12'($urandom());
               mode  = 2'($urandom_range(0, 3));
               equal = 1'($urandom_range(0, 1));
               case ($urandom_range(0, 3))
                  0:       pulse = 16'($urandom_range(1, 12));
                  1:       pulse = 16'hFFFF;
                  2:       pulse = psq_pkg::PULSE_SAMPLES_RESET;
                  default: pulse = 16'($urandom_range(0, 5));
               endcase
               apply_setting(mask, mode, equal, pulse);
            end
         endcase

         // every third phase runs without sender gaps
         gaps_on    = (phase % 3 != 0);
         burst_left = 0;
         rush_left  = 0;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // Long receiver hold-off while samples keep coming: fill the block.
            if (phase == 4 && k == 20) begin
               hold_request = 1'b1;
               rush_left    = 30;
            end
            // Pause mid-phase until every result is back.
            if (phase == 6 && k == 40) settle();

            if (rush_left > 0) begin
               rush_left--;
            end else if (burst_left == 0) begin
               if (gaps_on && $urandom_range(0, 3) != 0) begin
                  req_valid <= 1'b0;
                  repeat ($urandom_range(1, 8)) @(negedge clock);
               end
               burst_left = $urandom_range(1, 24);
            end else begin
               burst_left--;
            end

            // Favor a few channels so repeats and pulse overlap are common.
            ch = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom());
            case ($urandom_range(0, 6))
               0, 1: cv = int'($urandom_range(0, 131071)) - 65536;
               2:    cv = last_cv[ch];
               3:    cv = last_cv[ch] + int'($urandom_range(0, 600)) - 300;
               4:    cv = (int'($urandom_range(0, 511)) - 256) * SEMITONE_LSB
                          + int'($urandom_range(0, 2)) - 1
                          + ($urandom_range(0, 1) ? SEMITONE_LSB / 2 : 0);
               5:    cv = $urandom_range(0, 1) ? 65535 : -65536;
               default: cv = int'($urandom_range(0, 6143)) - OCTAVE_LSB;
            endcase
            if (cv > 65535) cv = 65535;
            if (cv < -65536) cv = -65536;
            case ($urandom_range(0, 3))
               0:       root = 0;
               1:       root = int'($urandom_range(0, 131071)) - 65536;
               2:       root = int'($urandom_range(0, 6144)) - OCTAVE_LSB;
               default: root = last_root[ch];
            endcase
            last_cv[ch]   = cv;
            last_root[ch] = root;
            send_sample(ch, 17'(cv), 17'(root), 1'b0, '0, 1'b0);
         end
      end

      // Drain, then wait TAIL_CYCLES more to show any stray result.
      req_valid <= 1'b0;
      while (expected_notes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d samples under %0d register settings;", samples_sent,
               settings_used);
      $display("%0d results compared, %0d of them with the trigger raised.", results_checked,
               triggers_seen);
      if (errors == 0) begin
         $display("[pitch_scale_quantizer_unit] OK");
      end else begin
         $display("[pitch_scale_quantizer_unit] ERROR");
      end
      $finish;
   end

endmodule
